>>> rtl/tlp_pkg.sv
// tlp_pkg: shared types and constants for the timer / LED register block.
// No dependencies; used by tlp_led, tlp_timer, timer_led_peripheral_regs and the bench.
package tlp_pkg;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Register map
  localparam logic [3:0] REG_LEDCTL   = 4'd0;
  localparam logic [3:0] REG_LEDSTAT  = 4'd1;
  localparam logic [3:0] REG_LEDDATA  = 4'd2;
  localparam logic [3:0] REG_INTENS   = 4'd3;
  localparam logic [3:0] REG_TCTL     = 4'd4;
  localparam logic [3:0] REG_TSTAT    = 4'd5;
  localparam logic [3:0] REG_COUNT    = 4'd6;
  localparam logic [3:0] REG_COMPARE  = 4'd7;
  localparam logic [3:0] REG_PRESCALE = 4'd8;
  localparam logic [3:0] REG_TINT     = 4'd9;
  localparam logic [3:0] REG_GLOBAL   = 4'd10;

  // Configuration port register indexes
  localparam logic [3:0] CFG_BLINK_PERIOD = 4'd0;
  localparam logic [3:0] CFG_TICK_DIVIDE  = 4'd1;

  // Reset values and limits
  localparam logic [7:0]  BLINK_PERIOD_RST = 8'd5;
  localparam logic [15:0] TICK_DIVIDE_RST  = 16'd10;
  localparam logic [7:0]  BLINK_MAX        = 8'hFF;
  localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;

  // One decoded word as seen by the units
  typedef struct packed {
    logic        tick;
    logic        wr;
    logic        rd;
    logic [3:0]  idx;
    logic [31:0] data;
  } op_t;

endpackage

>>> rtl/tlp_led.sv
// tlp_led: LED control unit (control, status, pattern, level, blink counter).
// Depends on tlp_pkg.
module tlp_led #(
  parameter int LED_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  tlp_pkg::op_t         op,
  input  logic [7:0]           blink_period,
  output logic [31:0]          rdata,
  output logic [LED_WIDTH-1:0] pattern_next
);

  logic [7:0]           led_control, led_control_next;
  logic                 led_enabled_flag, led_enabled_flag_next;
  logic [LED_WIDTH-1:0] pattern;
  logic [7:0]           led_level, led_level_next;
  logic [7:0]           blink_count, blink_count_next;

  // Compute next state for a tick or a register write
  always_comb begin
    logic [7:0] bc_inc;
    led_control_next      = led_control;
    led_enabled_flag_next = led_enabled_flag;
    pattern_next          = pattern;
    led_level_next        = led_level;
    blink_count_next      = blink_count;
    bc_inc = (blink_count < tlp_pkg::BLINK_MAX) ? blink_count + 8'd1 : blink_count;
    if (op.tick) begin
      if (led_control[0]) begin
        led_enabled_flag_next = 1'b1;
        if (led_control[1]) begin
          // saturate the counter, then invert on reaching the period
          if (bc_inc >= blink_period) begin
            blink_count_next = 8'd0;
            pattern_next     = ~pattern;
          end else begin
            blink_count_next = bc_inc;
          end
        end
      end else begin
        led_enabled_flag_next = 1'b0;
        pattern_next          = '0;
      end
    end else if (op.wr) begin
      case (op.idx)
        tlp_pkg::REG_LEDCTL:  led_control_next      = op.data[7:0];
        tlp_pkg::REG_LEDSTAT: led_enabled_flag_next = op.data[0];
        tlp_pkg::REG_LEDDATA: pattern_next          = op.data[LED_WIDTH-1:0];
        tlp_pkg::REG_INTENS:  led_level_next        = op.data[7:0];
        default: ;
      endcase
    end
  end

  // Read back this unit's registers
  always_comb begin
    rdata = 32'd0;
    if (op.rd) begin
      case (op.idx)
        tlp_pkg::REG_LEDCTL:  rdata = 32'(led_control);
        tlp_pkg::REG_LEDSTAT: rdata = 32'(led_enabled_flag);
        tlp_pkg::REG_LEDDATA: rdata = 32'(pattern);
        tlp_pkg::REG_INTENS:  rdata = 32'(led_level);
        default:              rdata = 32'd0;
      endcase
    end
  end

  // Commit state when the word leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      led_control      <= 8'd0;
      led_enabled_flag <= 1'b1;
      pattern          <= '0;
      led_level        <= 8'd0;
      blink_count      <= 8'd0;
    end else if (advance) begin
      led_control      <= led_control_next;
      led_enabled_flag <= led_enabled_flag_next;
      pattern          <= pattern_next;
      led_level        <= led_level_next;
      blink_count      <= blink_count_next;
    end
  end

endmodule

>>> rtl/tlp_timer.sv
// tlp_timer: compare-match timer with prescaler, sticky flags and global flags.
// Depends on tlp_pkg.
module tlp_timer (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  tlp_pkg::op_t op,
  input  logic [15:0]  tick_divide,
  output logic [31:0]  rdata,
  output logic         irq_next
);

  // timer_flags bits
  localparam int F_ENABLED = 0;
  localparam int F_RUNNING = 1;
  localparam int F_EXPIRED = 2;
  localparam int F_COMPARE = 3;

  logic [7:0]  timer_control, timer_control_next;
  logic [3:0]  timer_flags, timer_flags_next;
  logic [31:0] timer_count, timer_count_next;
  logic [31:0] timer_match, timer_match_next;
  logic [31:0] timer_scale, timer_scale_next;
  logic [2:0]  timer_irq_enable, timer_irq_enable_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  global_flags, global_flags_next;

  // Compute next state for a tick or a register write
  always_comb begin
    logic [15:0] tick_inc;
    logic [31:0] count_inc;
    timer_control_next    = timer_control;
    timer_flags_next      = timer_flags;
    timer_count_next      = timer_count;
    timer_match_next      = timer_match;
    timer_scale_next      = timer_scale;
    timer_irq_enable_next = timer_irq_enable;
    tick_count_next       = tick_count;
    global_flags_next     = global_flags;
    tick_inc  = tick_count + 16'd1;
    count_inc = timer_count + 32'd1;
    if (op.tick) begin
      if (timer_control[0]) begin
        // keep the sticky flags, mark enabled and running
        timer_flags_next[F_ENABLED] = 1'b1;
        timer_flags_next[F_RUNNING] = 1'b1;
        if (tick_inc >= tick_divide) begin
          tick_count_next  = 16'd0;
          timer_count_next = count_inc;
          if (count_inc == timer_match) begin
            timer_flags_next[F_COMPARE] = 1'b1;
            if (timer_irq_enable[0] && timer_irq_enable[2]) global_flags_next[7] = 1'b1;
          end
          if (count_inc == tlp_pkg::ALL_ONES) begin
            timer_flags_next[F_EXPIRED] = 1'b1;
            if (timer_irq_enable[0] && timer_irq_enable[1]) global_flags_next[7] = 1'b1;
            if (timer_control[2]) begin
              timer_count_next = 32'd0;
            end else if (timer_control[1]) begin
              timer_control_next[0]       = 1'b0;
              timer_flags_next[F_RUNNING] = 1'b0;
            end
          end
        end else begin
          tick_count_next = tick_inc;
        end
      end else begin
        timer_flags_next[F_ENABLED] = 1'b0;
        timer_flags_next[F_RUNNING] = 1'b0;
      end
    end else if (op.wr) begin
      case (op.idx)
        tlp_pkg::REG_TCTL:     timer_control_next    = op.data[7:0];
        tlp_pkg::REG_TSTAT:    timer_flags_next      = op.data[3:0];
        tlp_pkg::REG_COUNT:    timer_count_next      = op.data;
        tlp_pkg::REG_COMPARE:  timer_match_next      = op.data;
        tlp_pkg::REG_PRESCALE: timer_scale_next      = op.data;
        tlp_pkg::REG_TINT:     timer_irq_enable_next = op.data[2:0];
        tlp_pkg::REG_GLOBAL:   global_flags_next     = op.data[7:0];
        default: ;
      endcase
    end
  end

  assign irq_next = global_flags_next[7];

  // Read back this unit's registers
  always_comb begin
    rdata = 32'd0;
    if (op.rd) begin
      case (op.idx)
        tlp_pkg::REG_TCTL:     rdata = 32'(timer_control);
        tlp_pkg::REG_TSTAT:    rdata = 32'(timer_flags);
        tlp_pkg::REG_COUNT:    rdata = timer_count;
        tlp_pkg::REG_COMPARE:  rdata = timer_match;
        tlp_pkg::REG_PRESCALE: rdata = timer_scale;
        tlp_pkg::REG_TINT:     rdata = 32'(timer_irq_enable);
        tlp_pkg::REG_GLOBAL:   rdata = 32'(global_flags);
        default:               rdata = 32'd0;
      endcase
    end
  end

  // Commit state when the word leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_control    <= 8'd0;
      timer_flags      <= 4'd1;
      timer_count      <= 32'd0;
      timer_match      <= 32'd0;
      timer_scale      <= 32'd0;
      timer_irq_enable <= 3'd0;
      tick_count       <= 16'd0;
      global_flags     <= 8'd1;
    end else if (advance) begin
      timer_control    <= timer_control_next;
      timer_flags      <= timer_flags_next;
      timer_count      <= timer_count_next;
      timer_match      <= timer_match_next;
      timer_scale      <= timer_scale_next;
      timer_irq_enable <= timer_irq_enable_next;
      tick_count       <= tick_count_next;
      global_flags     <= global_flags_next;
    end
  end

endmodule

>>> rtl/timer_led_peripheral_regs.sv
// timer_led_peripheral_regs: timer and LED register block, one result word per input word.
// Each result word passes through the input register and then the result register.
// Throughput: one word per cycle; input stalls only while both registers hold a word and
// the result word is not taken. Reset (rst, synchronous): pipeline empty, all registers at
// their documented reset values, blink_period = 5 and tick_divide = 10.
// Depends on tlp_pkg, tlp_led, tlp_timer.
module timer_led_peripheral_regs #(
  parameter int LED_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        irq_pending,
  output logic [7:0]  led_pattern,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  blink_period;
  logic [15:0] tick_divide;

  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [3:0]  s1_idx;
  logic [31:0] s1_data;
  logic        advance;

  tlp_pkg::op_t         op;
  logic [31:0]          led_rdata, tmr_rdata;
  logic [LED_WIDTH-1:0] pattern_next;
  logic                 irq_next;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= tlp_pkg::BLINK_PERIOD_RST;
      tick_divide  <= tlp_pkg::TICK_DIVIDE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tlp_pkg::CFG_BLINK_PERIOD: blink_period <= cfg_data[7:0];
        tlp_pkg::CFG_TICK_DIVIDE:  tick_divide  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: input stage moves on when the result register is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind <= kind;
      s1_idx  <= reg_index;
      s1_data <= write_data;
    end
  end

  // Decode the held word
  always_comb begin
    op.tick = (s1_kind == tlp_pkg::KIND_TICK);
    op.wr   = (s1_kind == tlp_pkg::KIND_WRITE);
    op.rd   = (s1_kind == tlp_pkg::KIND_READ);
    op.idx  = s1_idx;
    op.data = s1_data;
  end

  tlp_led #(
    .LED_WIDTH (LED_WIDTH)
  ) u_led (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .op           (op),
    .blink_period (blink_period),
    .rdata        (led_rdata),
    .pattern_next (pattern_next)
  );

  tlp_timer u_timer (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .op          (op),
    .tick_divide (tick_divide),
    .rdata       (tmr_rdata),
    .irq_next    (irq_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data   <= led_rdata | tmr_rdata;
      irq_pending <= irq_next;
      led_pattern <= 8'(32'(pattern_next));
    end
  end

endmodule

>>> rtl/tlp_checker.sv
// tlp_checker: port-level checks for timer_led_peripheral_regs, attached by bind.
// Depends only on the top-level ports.
module tlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        irq_pending,
  input logic [7:0]  led_pattern,
  input logic        cfg_ready
);

  // Hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) &&
      $stable(irq_pending) && $stable(led_pattern))
    else $error("result word changed while stalled");

  // Drop all words on reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Take input whenever the result register is empty
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Configuration port never stalls
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind timer_led_peripheral_regs tlp_checker u_tlp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .read_data   (read_data),
  .irq_pending (irq_pending),
  .led_pattern (led_pattern),
  .cfg_ready   (cfg_ready)
);

>>> tb/sv/timer_led_peripheral_regs_test.sv
`timescale 1ns / 100ps
// Self-checking bench for timer_led_peripheral_regs: tick, register write and read words
// against an in-bench model of the LED and timer registers. Depends on tlp_pkg and the RTL.
module timer_led_peripheral_regs_test;

  localparam logic [1:0] KIND_NONE  = 2'd3;  // no operation
  localparam logic [3:0] CFG_UNUSED = 4'd2;  // beyond the configuration list
  localparam logic [3:0] REG_UNKNOWN = 4'd15; // outside the register map
  localparam logic [3:0] TFLAG_ENABLED = 4'h1;
  localparam logic [3:0] TFLAG_RUNNING = 4'h2;
  localparam logic [3:0] TFLAG_EXPIRED = 4'h4;
  localparam logic [3:0] TFLAG_COMPARE = 4'h8;
  localparam logic [2:0] IRQ_MASTER  = 3'b001;
  localparam logic [2:0] IRQ_EXPIRED = 3'b010;
  localparam logic [2:0] IRQ_COMPARE = 3'b100;
  localparam int HOLD_CYCLES = 400;
  localparam int TIMEOUT_NS  = 2_000_000;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  idx;
    logic [31:0] data;
  } bus_word_t;

  typedef struct {
    logic [31:0] rdata;
    logic        irq;
    logic [7:0]  leds;
  } pin_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = tlp_pkg::KIND_TICK;
  logic [3:0]  reg_index = tlp_pkg::REG_LEDCTL;
  logic [31:0] write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic        irq_pending;
  logic [7:0]  led_pattern;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = tlp_pkg::CFG_BLINK_PERIOD;
  logic [15:0] cfg_data = '0;

  bus_word_t  word_queue[$];
  pin_state_t status_words[$];
  bus_word_t  queued_word;
  pin_state_t want;
  int         send_idle_pct = 11;
  int         recv_idle_pct = 77;
  int         mismatches = 0;
  logic       hold_go = 1'b0;
  logic       rx_hold = 1'b0;

  // Model state of the peripheral
  logic [7:0]  blink_period;
  logic [15:0] tick_divide;
  logic [7:0]  led_ctl;
  logic        led_on;
  logic [7:0]  led_bits;
  logic [7:0]  led_level;
  logic [7:0]  blink_cnt;
  logic [7:0]  tmr_ctl;
  logic [3:0]  tmr_flags;
  logic [31:0] tmr_count;
  logic [31:0] tmr_match;
  logic [31:0] tmr_scale;
  logic [2:0]  tmr_irq_en;
  logic [15:0] tick_cnt;
  logic [7:0]  glb_flags;

  timer_led_peripheral_regs uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .reg_index(reg_index), .write_data(write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .irq_pending(irq_pending), .led_pattern(led_pattern),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic reset_model();
    blink_period = tlp_pkg::BLINK_PERIOD_RST;
    tick_divide  = tlp_pkg::TICK_DIVIDE_RST;
    led_ctl      = '0;
    led_on       = 1'b1;
    led_bits     = '0;
    led_level    = '0;
    blink_cnt    = '0;
    tmr_ctl      = '0;
    tmr_flags    = TFLAG_ENABLED;
    tmr_count    = '0;
    tmr_match    = '0;
    tmr_scale    = '0;
    tmr_irq_en   = '0;
    tick_cnt     = '0;
    glb_flags    = 8'h01;
  endtask

  // Set the pending interrupt when the master and the source are enabled
  function automatic void flag_irq(input logic [2:0] src);
    if ((tmr_irq_en & IRQ_MASTER) != 0 && (tmr_irq_en & src) != 0)
      glb_flags[7] = 1'b1;
  endfunction

  // Advance the register state by one word and return the pins it leaves behind
  function automatic pin_state_t apply_word(input bus_word_t w);
    pin_state_t res;
    res.rdata = '0;
    case (w.kind)
      tlp_pkg::KIND_TICK: begin
        // LED unit: blink or clear
        if (led_ctl[0]) begin
          led_on = 1'b1;
          if (led_ctl[1]) begin
            if (blink_cnt < tlp_pkg::BLINK_MAX)
              blink_cnt = blink_cnt + 8'd1;
            if (blink_cnt >= blink_period) begin
              blink_cnt = '0;
              led_bits  = ~led_bits;
            end
          end
        end else begin
          led_on   = 1'b0;
          led_bits = '0;
        end
        // Timer: prescaled count, compare and terminal count
        if (tmr_ctl[0]) begin
          tmr_flags = (tmr_flags & (TFLAG_EXPIRED | TFLAG_COMPARE))
                      | TFLAG_ENABLED | TFLAG_RUNNING;
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= tick_divide) begin
            tick_cnt  = '0;
            tmr_count = tmr_count + 32'd1;
            if (tmr_count == tmr_match) begin
              tmr_flags = tmr_flags | TFLAG_COMPARE;
              flag_irq(IRQ_COMPARE);
            end
            if (tmr_count == tlp_pkg::ALL_ONES) begin
              tmr_flags = tmr_flags | TFLAG_EXPIRED;
              flag_irq(IRQ_EXPIRED);
              if (tmr_ctl[2]) begin
                tmr_count = '0;
              end else if (tmr_ctl[1]) begin
                tmr_ctl[0] = 1'b0;
                tmr_flags  = tmr_flags & ~TFLAG_RUNNING;
              end
            end
          end
        end else begin
          tmr_flags = tmr_flags & ~(TFLAG_ENABLED | TFLAG_RUNNING);
        end
      end
      tlp_pkg::KIND_WRITE: begin
        case (w.idx)
          tlp_pkg::REG_LEDCTL:   led_ctl    = w.data[7:0];
          tlp_pkg::REG_LEDSTAT:  led_on     = w.data[0];
          tlp_pkg::REG_LEDDATA:  led_bits   = w.data[7:0];
          tlp_pkg::REG_INTENS:   led_level  = w.data[7:0];
          tlp_pkg::REG_TCTL:     tmr_ctl    = w.data[7:0];
          tlp_pkg::REG_TSTAT:    tmr_flags  = w.data[3:0];
          tlp_pkg::REG_COUNT:    tmr_count  = w.data;
          tlp_pkg::REG_COMPARE:  tmr_match  = w.data;
          tlp_pkg::REG_PRESCALE: tmr_scale  = w.data;
          tlp_pkg::REG_TINT:     tmr_irq_en = w.data[2:0];
          tlp_pkg::REG_GLOBAL:   glb_flags  = w.data[7:0];
          default: ;
        endcase
      end
      tlp_pkg::KIND_READ: begin
        case (w.idx)
          tlp_pkg::REG_LEDCTL:   res.rdata = 32'(led_ctl);
          tlp_pkg::REG_LEDSTAT:  res.rdata = 32'(led_on);
          tlp_pkg::REG_LEDDATA:  res.rdata = 32'(led_bits);
          tlp_pkg::REG_INTENS:   res.rdata = 32'(led_level);
          tlp_pkg::REG_TCTL:     res.rdata = 32'(tmr_ctl);
          tlp_pkg::REG_TSTAT:    res.rdata = 32'(tmr_flags);
          tlp_pkg::REG_COUNT:    res.rdata = tmr_count;
          tlp_pkg::REG_COMPARE:  res.rdata = tmr_match;
          tlp_pkg::REG_PRESCALE: res.rdata = tmr_scale;
          tlp_pkg::REG_TINT:     res.rdata = 32'(tmr_irq_en);
          tlp_pkg::REG_GLOBAL:   res.rdata = 32'(glb_flags);
          default:               res.rdata = '0;
        endcase
      end
      default: ;
    endcase
    res.irq  = glb_flags[7];
    res.leds = led_bits;
    return res;
  endfunction

  function automatic bus_word_t random_word();
    bus_word_t w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45)      w.kind = tlp_pkg::KIND_TICK;
    else if (pick < 72) w.kind = tlp_pkg::KIND_WRITE;
    else if (pick < 95) w.kind = tlp_pkg::KIND_READ;
    else                w.kind = KIND_NONE;
    if ($urandom_range(9) == 0) w.idx = 4'($urandom_range(15, 11));
    else                        w.idx = 4'($urandom_range(10));
    // Mix small values and values near the terminal count so compares and wraps happen
    case ($urandom_range(3))
      0: w.data = $urandom;
      1: w.data = $urandom_range(15);
      2: w.data = tlp_pkg::ALL_ONES - $urandom_range(15);
      default: w.data = $urandom_range(255);
    endcase
    return w;
  endfunction

  task automatic queue_word(input logic [1:0] k, input logic [3:0] idx, input logic [31:0] d);
    bus_word_t w;
    w.kind = k;
    w.idx  = idx;
    w.data = d;
    word_queue.push_back(w);
  endtask

  task automatic queue_random_words(input int count);
    repeat (count) word_queue.push_back(random_word());
  endtask

  // Write one configuration register; call only while the block is idle
  task automatic write_cfg(input logic [3:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == tlp_pkg::CFG_BLINK_PERIOD)
      blink_period = value[7:0];
    else if (index == tlp_pkg::CFG_TICK_DIVIDE)
      tick_divide = value;
  endtask

  // Wait until every word has gone through, then let the pipeline settle
  task automatic drain();
    while (word_queue.size() != 0 || in_valid || status_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  // Driver: predict each accepted word, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        queued_word.kind = kind;
        queued_word.idx  = reg_index;
        queued_word.data = write_data;
        status_words.push_back(apply_word(queued_word));
      end
      if (!in_valid || in_ready) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          queued_word = word_queue.pop_front();
          in_valid   <= 1'b1;
          kind       <= queued_word.kind;
          reg_index  <= queued_word.idx;
          write_data <= queued_word.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (status_words.size() == 0) begin
        flag_mismatch("unexpected result word", read_data, '0);
      end else begin
        want = status_words.pop_front();
        if (read_data !== want.rdata)
          flag_mismatch("read_data", read_data, want.rdata);
        if (irq_pending !== want.irq)
          flag_mismatch("irq_pending", 32'(irq_pending), 32'(want.irq));
        if (led_pattern !== want.leds)
          flag_mismatch("led_pattern", 32'(led_pattern), 32'(want.leds));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: periods of one so every tick acts
    write_cfg(tlp_pkg::CFG_BLINK_PERIOD, 16'd1);
    write_cfg(tlp_pkg::CFG_TICK_DIVIDE, 16'd1);
    write_cfg(CFG_UNUSED, 16'hFFFF);
    queue_word(tlp_pkg::KIND_TICK,  tlp_pkg::REG_LEDCTL,   '0);  // disabled LED clears
    // enable, blink, bit 7 set
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_LEDCTL,   32'h0000_0083);
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_LEDDATA,  32'hFFFF_FFA5);
    queue_word(tlp_pkg::KIND_TICK,  tlp_pkg::REG_LEDCTL,   '0);  // invert pattern
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_TINT,     tlp_pkg::ALL_ONES);
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_COMPARE,  32'hFFFF_FFFE);
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_COUNT,    32'hFFFF_FFFD);
    // enable, reload, bit 7 set
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_TCTL,     32'h0000_0085);
    queue_word(tlp_pkg::KIND_TICK,  tlp_pkg::REG_LEDCTL,   '0);  // compare match
    queue_word(tlp_pkg::KIND_TICK,  tlp_pkg::REG_LEDCTL,   '0);  // terminal count, reload
    queue_word(tlp_pkg::KIND_READ,  tlp_pkg::REG_TSTAT,    '0);
    // clear pending interrupt
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_GLOBAL,   32'h0000_0001);
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_TSTAT,    '0);  // clear sticky flags
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_COUNT,    tlp_pkg::ALL_ONES);
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_TCTL,     32'h0000_0001);
    queue_word(tlp_pkg::KIND_TICK,  tlp_pkg::REG_LEDCTL,   '0);  // counter wraps to zero
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_COUNT,    32'hFFFF_FFFE);
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_TCTL,     32'h0000_0003);  // one-shot
    queue_word(tlp_pkg::KIND_TICK,  tlp_pkg::REG_LEDCTL,   '0);  // one-shot stops the timer
    queue_word(tlp_pkg::KIND_TICK,  tlp_pkg::REG_LEDCTL,   '0);  // stopped: keep sticky flags
    queue_word(tlp_pkg::KIND_READ,  tlp_pkg::REG_TCTL,     '0);
    queue_word(KIND_NONE,           tlp_pkg::REG_COUNT,    tlp_pkg::ALL_ONES);
    queue_word(tlp_pkg::KIND_WRITE, REG_UNKNOWN,           tlp_pkg::ALL_ONES);
    queue_word(tlp_pkg::KIND_READ,  REG_UNKNOWN,           tlp_pkg::ALL_ONES);
    queue_word(tlp_pkg::KIND_WRITE, tlp_pkg::REG_PRESCALE, tlp_pkg::ALL_ONES);
    queue_word(tlp_pkg::KIND_READ,  tlp_pkg::REG_PRESCALE, '0);
    drain();

    // Random, highest periods
    write_cfg(tlp_pkg::CFG_BLINK_PERIOD, 16'd255);
    write_cfg(tlp_pkg::CFG_TICK_DIVIDE, 16'hFFFF);
    queue_random_words(100);
    drain();

    // Random, zero periods, sender idles more, receiver holds off once
    write_cfg(tlp_pkg::CFG_BLINK_PERIOD, 16'd0);
    write_cfg(tlp_pkg::CFG_TICK_DIVIDE, 16'd0);
    send_idle_pct <= 77;
    recv_idle_pct <= 11;
    hold_go = 1'b1;
    queue_random_words(200);
    drain();

    // Random, short periods, no idling
    write_cfg(tlp_pkg::CFG_BLINK_PERIOD, 16'($urandom_range(8, 1)));
    write_cfg(tlp_pkg::CFG_TICK_DIVIDE, 16'($urandom_range(4, 1)));
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_random_words(200);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
